### hw/rtl/olkd_pkg.sv
// Package for the ordered list key-delete block: command and response beat
// types, opcode and status codes, controller interface structs and the FSM states.
// No dependencies.
`timescale 1ns / 1ps

package olkd_pkg;

    // Default number of list slots.
    localparam int unsigned OLKD_DEPTH = 16;

    // Opcodes carried in a command beat.
    localparam logic [2:0] OP_APPEND      = 3'd0;
    localparam logic [2:0] OP_DEL_HEAD    = 3'd1;
    localparam logic [2:0] OP_DEL_TAIL    = 3'd2;
    localparam logic [2:0] OP_DEL_AFTER   = 3'd3;
    localparam logic [2:0] OP_DEL_BEFORE  = 3'd4;

    // Status codes carried in a response beat.
    localparam logic [1:0] STAT_DONE = 2'd0;
    localparam logic [1:0] STAT_MISS = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] item_value;
    } cmd_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] removed_value;
        logic [4:0]         entry_total;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic commit;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } dp_stat_t;

    typedef enum logic {
        S_IDLE,
        S_UPDATE
    } state_t;

endpackage

### hw/rtl/olkd_ctrl.sv
// Controller for the ordered list block: a two-state machine that captures a
// command beat and then commits it once the response register is free.
// Depends on olkd_pkg.
`timescale 1ns / 1ps

module olkd_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  olkd_pkg::dp_stat_t  dp_stat,
    output olkd_pkg::ctrl_cmd_t ctrl_cmd
);

    olkd_pkg::state_t state_reg;
    olkd_pkg::state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= olkd_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            olkd_pkg::S_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = olkd_pkg::S_UPDATE;
                end
            end
            olkd_pkg::S_UPDATE:
            begin
                if (dp_stat.out_free)
                begin
                    state_next = olkd_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = olkd_pkg::S_IDLE;
            end
        endcase
    end

    // Output logic.
    always_comb
    begin
        cmd_ready        = 1'b0;
        ctrl_cmd.capture = 1'b0;
        ctrl_cmd.commit  = 1'b0;
        unique case (state_reg)
            olkd_pkg::S_IDLE:
            begin
                cmd_ready        = 1'b1;
                ctrl_cmd.capture = cmd_valid;
            end
            olkd_pkg::S_UPDATE:
            begin
                ctrl_cmd.commit = dp_stat.out_free;
            end
            default:
            begin
                cmd_ready = 1'b0;
            end
        endcase
    end

endmodule

### hw/rtl/olkd_datapath.sv
// Datapath for the ordered list block: a row of value cells with per-cell key
// compare, the removal select and shift, the entry count and the response register.
// Depends on olkd_pkg.
`timescale 1ns / 1ps

module olkd_datapath
#(
    parameter int unsigned DEPTH = olkd_pkg::OLKD_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  olkd_pkg::cmd_t      cmd,
    input  olkd_pkg::ctrl_cmd_t ctrl_cmd,
    output olkd_pkg::dp_stat_t  dp_stat,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output olkd_pkg::rsp_t      rsp
);

    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic signed [31:0] cell_reg [DEPTH];
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [2:0]         op_reg;
    logic signed [31:0] key_reg;
    logic [DEPTH-1:0]   match_reg;

    logic [DEPTH-1:0]   valid_vec;
    logic [DEPTH-1:0]   match_now;
    logic [DEPTH-1:0]   first_vec;
    logic [DEPTH-1:0]   rm_vec;
    logic [DEPTH-1:0]   shift_vec;
    logic [DEPTH-1:0]   below_any;
    logic [DEPTH-1:0]   upto_rm;
    logic               found;
    logic               full;
    logic               is_empty;
    logic [CW-1:0]      tail_idx;
    logic signed [31:0] removed;
    logic [1:0]         status;
    logic [CW+4:0]      count_ext;

    logic               rsp_valid_reg;
    olkd_pkg::rsp_t     rsp_reg;

    assign full     = (count_reg == CW'(DEPTH));
    assign is_empty = (count_reg == '0);
    assign tail_idx = count_reg - CW'(1);

    // Per-cell occupancy and key compare against the incoming beat.
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            valid_vec[i] = (CW'(i) < count_reg);
            match_now[i] = valid_vec[i] && (cell_reg[i] == cmd.item_value);
        end
    end

    // Command and match vector captured at the accept edge.
    always_ff @(posedge clk)
    begin
        if (ctrl_cmd.capture)
        begin
            op_reg    <= cmd.opcode;
            key_reg   <= cmd.item_value;
            match_reg <= match_now;
        end
    end

    // First match from the head.
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            below_any[i] = 1'b0;
            for (int j = 0; j < DEPTH; j++)
            begin
                if (j < i)
                begin
                    below_any[i] = below_any[i] | match_reg[j];
                end
            end
            first_vec[i] = match_reg[i] & ~below_any[i];
        end
    end

    // Prefix of the removal point: every cell from there on takes its successor.
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            upto_rm[i] = 1'b0;
            for (int j = 0; j < DEPTH; j++)
            begin
                if (j <= i)
                begin
                    upto_rm[i] = upto_rm[i] | rm_vec[j];
                end
            end
        end
    end

    // One-hot select of the slot to remove.
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_rm
            logic after_hit;
            logic before_hit;
            if (g > 0)
            begin : g_after
                assign after_hit = first_vec[g-1] & valid_vec[g];
            end
            else
            begin : g_no_after
                assign after_hit = 1'b0;
            end
            if (g < DEPTH - 1)
            begin : g_before
                assign before_hit = first_vec[g+1];
            end
            else
            begin : g_no_before
                assign before_hit = 1'b0;
            end

            always_comb
            begin
                case (op_reg)
                    olkd_pkg::OP_DEL_HEAD:   rm_vec[g] = (g == 0) && !is_empty;
                    olkd_pkg::OP_DEL_TAIL:   rm_vec[g] = !is_empty && (tail_idx == CW'(g));
                    olkd_pkg::OP_DEL_AFTER:  rm_vec[g] = after_hit;
                    olkd_pkg::OP_DEL_BEFORE: rm_vec[g] = before_hit;
                    default:                 rm_vec[g] = 1'b0;
                endcase
            end
        end
    endgenerate

    assign found     = |rm_vec;
    assign shift_vec = upto_rm;

    // Value of the removed slot.
    always_comb
    begin
        removed = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (rm_vec[i])
            begin
                removed = removed | cell_reg[i];
            end
        end
    end

    // Status and the entry count after the command.
    always_comb
    begin
        status     = olkd_pkg::STAT_MISS;
        count_next = count_reg;
        case (op_reg) inside
            olkd_pkg::OP_APPEND:
            begin
                if (full)
                begin
                    status = olkd_pkg::STAT_FULL;
                end
                else
                begin
                    status     = olkd_pkg::STAT_DONE;
                    count_next = count_reg + CW'(1);
                end
            end
            olkd_pkg::OP_DEL_HEAD, olkd_pkg::OP_DEL_TAIL,
            olkd_pkg::OP_DEL_AFTER, olkd_pkg::OP_DEL_BEFORE:
            begin
                if (found)
                begin
                    status     = olkd_pkg::STAT_DONE;
                    count_next = count_reg - CW'(1);
                end
            end
            default:
            begin
                status = olkd_pkg::STAT_MISS;
            end
        endcase
    end

    // Cell row: append writes the slot at the count, removal shifts later cells up.
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic signed [31:0] succ;
            if (g < DEPTH - 1)
            begin : g_succ
                assign succ = cell_reg[g+1];
            end
            else
            begin : g_last
                assign succ = cell_reg[g];
            end

            always_ff @(posedge clk)
            begin
                if (ctrl_cmd.commit)
                begin
                    if (op_reg == olkd_pkg::OP_APPEND && !full && count_reg == CW'(g))
                    begin
                        cell_reg[g] <= key_reg;
                    end
                    else if (shift_vec[g])
                    begin
                        cell_reg[g] <= succ;
                    end
                end
            end
        end
    endgenerate

    // Entry count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (ctrl_cmd.commit)
        begin
            count_reg <= count_next;
        end
    end

    assign count_ext = {5'd0, count_next};

    // Response register; the controller commits only when it is free.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (ctrl_cmd.commit)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_cmd.commit)
        begin
            rsp_reg.status        <= status;
            rsp_reg.removed_value <= found ? removed : 32'sd0;
            rsp_reg.entry_total   <= count_ext[4:0];
        end
    end

    assign dp_stat.out_free = !rsp_valid_reg || rsp_ready;
    assign rsp_valid        = rsp_valid_reg;
    assign rsp              = rsp_reg;

    // The list never holds more entries than it has slots.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    // A commit never overwrites a response that is still waiting.
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_cmd.commit |-> (!rsp_valid_reg || rsp_ready))
        else $error("commit while response pending");

    // The count moves only on a commit.
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !ctrl_cmd.commit |=> $stable(count_reg))
        else $error("entry count changed without commit");

    // At most one slot is removed per command.
    a_rm_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(rm_vec))
        else $error("more than one slot selected for removal");

endmodule

### hw/rtl/ordered_list_key_delete.sv
// Top level of the ordered list key-delete block: joins the controller and the
// datapath. Depends on olkd_pkg, olkd_ctrl and olkd_datapath.
//
//   channel   direction   handshake              beat
//   cmd       in          cmd_valid / cmd_ready  olkd_pkg::cmd_t (opcode, item_value)
//   rsp       out         rsp_valid / rsp_ready  olkd_pkg::rsp_t (status, removed_value,
//                                                entry_total)
//
// Each command is handled in two steps: the accept edge captures the command together
// with the key compare of every cell, and a later edge in S_UPDATE commits the removal shift
// or append and loads the response register once that register is free.
// A new command is accepted in the cycle after a commit, while the response waits.
// The commit stalls while an earlier response is still held by rsp_ready low.
// Reset empties the list; no clearing pass is needed.
`timescale 1ns / 1ps

module ordered_list_key_delete
#(
    parameter int unsigned DEPTH = olkd_pkg::OLKD_DEPTH
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  olkd_pkg::cmd_t cmd,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output olkd_pkg::rsp_t rsp
);

    olkd_pkg::ctrl_cmd_t ctrl_cmd;
    olkd_pkg::dp_stat_t  dp_stat;

    // Sequencing of capture and commit.
    olkd_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .dp_stat   (dp_stat),
        .ctrl_cmd  (ctrl_cmd)
    );

    // List storage, search and response.
    olkd_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .ctrl_cmd  (ctrl_cmd),
        .dp_stat   (dp_stat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

### tb/ordered_list_key_delete_tb.sv
// Self-checking testbench for ordered_list_key_delete: drives command beats, predicts
// each response beat from a shadow copy of the list and compares it field by field.
// Depends on olkd_pkg and the ordered_list_key_delete RTL.
`timescale 1ns / 1ps

module ordered_list_key_delete_tb;

    localparam int unsigned LIST_DEPTH  = olkd_pkg::OLKD_DEPTH;
    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned HOLD_CYCLES = 80;
    localparam int unsigned TAIL_CYCLES = 20;

    // Opcodes the block does not define; they must leave the list alone.
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

    // Shadow of the list contents plus the queue of responses still owed by the block.
    class list_shadow;
        logic signed [31:0] slots [LIST_DEPTH];
        int unsigned        fill;
        olkd_pkg::rsp_t     owed_responses [$];
        int unsigned        mismatches;

        function new();
            fill        = 0;
            mismatches  = 0;
        endfunction

        function int unsigned size();
            return fill;
        endfunction

        function int unsigned pending();
            return owed_responses.size();
        endfunction

        function logic signed [31:0] entry_at(int unsigned idx);
            return slots[idx];
        endfunction

        // Index of the first entry equal to the key, or the fill level if absent.
        function int unsigned find_first(logic signed [31:0] key);
            for (int unsigned i = 0; i < fill; i++)
            begin
                if (slots[i] == key)
                    return i;
            end
            return fill;
        endfunction

        // Remove one slot and close the gap so the list stays packed.
        function logic signed [31:0] take_slot(int unsigned idx);
            logic signed [31:0] taken;
            taken = slots[idx];
            for (int unsigned i = idx; i + 1 < fill; i++)
            begin
                slots[i] = slots[i + 1];
            end
            fill--;
            return taken;
        endfunction

        // Apply one accepted command beat and queue the response it must produce.
        function void note_command(olkd_pkg::cmd_t c);
            olkd_pkg::rsp_t r;
            int unsigned    pos;
            r.status        = olkd_pkg::STAT_MISS;
            r.removed_value = '0;
            case (c.opcode)
                olkd_pkg::OP_APPEND:
                begin
                    if (fill >= LIST_DEPTH)
                        r.status = olkd_pkg::STAT_FULL;
                    else
                    begin
                        slots[fill] = c.item_value;
                        fill++;
                        r.status = olkd_pkg::STAT_DONE;
                    end
                end
                olkd_pkg::OP_DEL_HEAD:
                begin
                    if (fill > 0)
                    begin
                        r.removed_value = take_slot(0);
                        r.status        = olkd_pkg::STAT_DONE;
                    end
                end
                olkd_pkg::OP_DEL_TAIL:
                begin
                    if (fill > 0)
                    begin
                        r.removed_value = take_slot(fill - 1);
                        r.status        = olkd_pkg::STAT_DONE;
                    end
                end
                olkd_pkg::OP_DEL_AFTER:
                begin
                    pos = find_first(c.item_value);
                    if (pos + 1 < fill)
                    begin
                        r.removed_value = take_slot(pos + 1);
                        r.status        = olkd_pkg::STAT_DONE;
                    end
                end
                olkd_pkg::OP_DEL_BEFORE:
                begin
                    pos = find_first(c.item_value);
                    if (pos < fill && pos > 0)
                    begin
                        r.removed_value = take_slot(pos - 1);
                        r.status        = olkd_pkg::STAT_DONE;
                    end
                end
                default:
                begin
                end
            endcase
            r.entry_total = fill[4:0];
            owed_responses.push_back(r);
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        // Compare an accepted response beat with the oldest one owed.
        task check_response(olkd_pkg::rsp_t got);
            olkd_pkg::rsp_t want;
            if (owed_responses.size() == 0)
            begin
                report_mismatch($sformatf("unexpected response beat %p", got));
                return;
            end
            want = owed_responses.pop_front();
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
            if (got.removed_value !== want.removed_value)
                report_mismatch($sformatf("removed_value %0d, expected %0d",
                                          got.removed_value, want.removed_value));
            if (got.entry_total !== want.entry_total)
                report_mismatch($sformatf("entry_total %0d, expected %0d",
                                          got.entry_total, want.entry_total));
        endtask
    endclass

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           cmd_valid = 1'b0;
    logic           cmd_ready;
    olkd_pkg::cmd_t cmd       = '0;
    logic           rsp_valid;
    logic           rsp_ready = 1'b0;
    olkd_pkg::rsp_t rsp;

    list_shadow  sb;
    int unsigned sender_idle_pct   = 0;
    int unsigned receiver_idle_pct = 0;
    int unsigned hold_request      = 0;
    int unsigned hold_left         = 0;
    int unsigned quiet_cycles      = 0;
    int unsigned fill_target       = 0;

    ordered_list_key_delete DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // Free-running clock.
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Response side: check accepted beats, then decide readiness for the next edge.
    always @(posedge clk)
    begin
        if (rsp_valid && rsp_ready)
            sb.check_response(rsp);
        if (hold_request != 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end

    // Watchdog: give up when no beat moves on either channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Offer one command beat, with an optional idle gap first, and wait for acceptance.
    task automatic send_command(logic [2:0] op, logic signed [31:0] val);
        olkd_pkg::cmd_t c;
        int unsigned    gap;
        c.opcode     = op;
        c.item_value = val;
        gap = ($urandom_range(0, 99) < sender_idle_pct) ? $urandom_range(1, 4) : 0;
        if (gap != 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        sb.note_command(c);
    endtask

    // Stop offering and wait until every owed response has come back.
    task automatic wait_drained();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Mix of duplicates from a small pool, extremes and fully random words.
    function automatic logic signed [31:0] random_value();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return $signed(32'($urandom_range(0, 7))) - 32'sd4;
        else if (roll < 50)
            return ($urandom_range(0, 1) != 0) ? VAL_MIN : VAL_MAX;
        else
            return $signed($urandom);
    endfunction

    // Pick a command that keeps the list moving towards a wandering fill target.
    task automatic send_random_command();
        logic [2:0]         op;
        logic signed [31:0] val;
        int unsigned        n;
        n = sb.size();
        if ($urandom_range(0, 99) < 3)
            op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
        else if ($urandom_range(0, 99) < ((n < fill_target) ? 70 : 20))
            op = olkd_pkg::OP_APPEND;
        else
        begin
            case ($urandom_range(0, 3))
                0:       op = olkd_pkg::OP_DEL_HEAD;
                1:       op = olkd_pkg::OP_DEL_TAIL;
                2:       op = olkd_pkg::OP_DEL_AFTER;
                default: op = olkd_pkg::OP_DEL_BEFORE;
            endcase
        end
        // Keys mostly come from the list itself so that searches hit.
        if ((op == olkd_pkg::OP_DEL_AFTER || op == olkd_pkg::OP_DEL_BEFORE) && n > 0
            && $urandom_range(0, 99) < 85)
            val = sb.entry_at($urandom_range(0, n - 1));
        else
            val = random_value();
        send_command(op, val);
    endtask

    task automatic run_phase(int unsigned items, int unsigned s_pct, int unsigned r_pct,
                             bit with_hold);
        sender_idle_pct   = s_pct;
        receiver_idle_pct = r_pct;
        for (int unsigned i = 0; i < items; i++)
        begin
            if (i % 24 == 0)
                fill_target = ($urandom_range(0, 99) < 30) ? LIST_DEPTH
                                                           : $urandom_range(0, LIST_DEPTH);
            // Long receiver stall while commands keep coming, so the block backs up.
            if (with_hold && i == items / 2)
                hold_request = HOLD_CYCLES;
            send_random_command();
        end
        wait_drained();
    endtask

    // Main sequence: reset, directed cases, three random phases, then the verdict.
    initial
    begin
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every delete on an empty list, and an undefined opcode.
        send_command(olkd_pkg::OP_DEL_HEAD, 32'sd0);
        send_command(olkd_pkg::OP_DEL_TAIL, 32'sd0);
        send_command(olkd_pkg::OP_DEL_AFTER, 32'sd0);
        send_command(olkd_pkg::OP_DEL_BEFORE, 32'sd0);
        send_command(OP_SPARE_LAST, VAL_MAX);
        // Extremes of the value field, with a duplicate key.
        send_command(olkd_pkg::OP_APPEND, VAL_MIN);
        send_command(olkd_pkg::OP_APPEND, VAL_MAX);
        send_command(olkd_pkg::OP_APPEND, 32'sd0);
        send_command(olkd_pkg::OP_APPEND, VAL_MAX);
        send_command(olkd_pkg::OP_APPEND, -32'sd1);
        // Key at the head has no predecessor; key at the tail has no successor.
        send_command(olkd_pkg::OP_DEL_BEFORE, VAL_MIN);
        send_command(olkd_pkg::OP_DEL_AFTER, -32'sd1);
        send_command(olkd_pkg::OP_DEL_AFTER, 32'sd12345);
        // Only the first of the duplicate keys counts.
        send_command(olkd_pkg::OP_DEL_AFTER, VAL_MAX);
        send_command(olkd_pkg::OP_DEL_BEFORE, VAL_MAX);
        send_command(olkd_pkg::OP_DEL_BEFORE, VAL_MAX);
        send_command(olkd_pkg::OP_DEL_TAIL, 32'sd0);
        send_command(olkd_pkg::OP_DEL_HEAD, 32'sd0);
        wait_drained();

        run_phase(165, 24, 46, 1'b0);
        run_phase(165, 46, 24, 1'b0);
        run_phase(170, 0, 0, 1'b1);

        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d responses never arrived", sb.pending()));
        if (sb.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### sim.f
hw/rtl/olkd_pkg.sv
hw/rtl/olkd_ctrl.sv
hw/rtl/olkd_datapath.sv
hw/rtl/ordered_list_key_delete.sv
tb/ordered_list_key_delete_tb.sv
